@@ rtl/core/bladc_pkg.sv @@
// ----------------------------------------------------------------------------
// bladc_pkg : shared definitions for the backlight auto-dim controller
// Register indexes, action codes, reset values, field widths and the
// configuration bundle passed from the register file to the event core.
// ----------------------------------------------------------------------------
package bladc_pkg;

   // field widths
   localparam int unsigned ACTION_W  = 2;
   localparam int unsigned DELTA_W   = 8;
   localparam int unsigned DUTY_W    = 10;
   localparam int unsigned PCT_W     = 7;
   localparam int unsigned TIMEOUT_W = 27;
   localparam int unsigned GRACE_W   = 16;
   localparam int unsigned COUNT_W   = 32;
   localparam int unsigned CSR_IDX_W = 3;
   localparam int unsigned CSR_DAT_W = 27;

   // limits
   localparam int unsigned PCT_LIMIT  = 100;
   localparam int unsigned DUTY_LIMIT = 1023;

   // parameter defaults
   localparam int unsigned DEFAULT_LEVEL_DEF = 80;
   localparam int unsigned DUTY_FULL_DEF     = 1023;

   // action codes
   localparam logic [ACTION_W-1:0] ACT_TICK     = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_ACTIVITY = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_STEP     = 2'd2;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_ENABLE = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_TIMEOUT = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIM_LEVEL  = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_MIN = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_BRIGHT_MAX = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_GRACE      = 3'd5;

   // register reset values
   localparam logic [TIMEOUT_W-1:0] RST_DIM_TIMEOUT = 27'd30000;
   localparam logic [PCT_W-1:0]     RST_DIM_LEVEL   = 7'd10;
   localparam logic [PCT_W-1:0]     RST_BRIGHT_MIN  = 7'd5;
   localparam logic [PCT_W-1:0]     RST_BRIGHT_MAX  = 7'd100;
   localparam logic [GRACE_W-1:0]   RST_GRACE       = 16'd500;

   typedef struct packed {
      logic                 dim_enable;
      logic [TIMEOUT_W-1:0] dim_timeout_ms;
      logic [PCT_W-1:0]     dim_level_percent;
      logic [PCT_W-1:0]     brightness_min;
      logic [PCT_W-1:0]     brightness_max;
      logic [GRACE_W-1:0]   grace_ms;
   } bladc_cfg_type;

   typedef struct packed {
      logic [DUTY_W-1:0] duty;
      logic              is_dimmed;
      logic              woke_up;
      logic              in_grace;
      logic [PCT_W-1:0]  brightness;
   } bladc_result_type;

endpackage

@@ rtl/core/bladc_csr.sv @@
// ----------------------------------------------------------------------------
// bladc_csr : configuration register file
// Write-only settings for auto-dim; writes to unknown indexes are dropped.
// ----------------------------------------------------------------------------
module bladc_csr
   import bladc_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [CSR_DAT_W-1:0] csr_data,
   output bladc_cfg_type        cfg
);

   bladc_cfg_type cfg_ff;
   bladc_cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         case (csr_index)
            CSR_DIM_ENABLE:  cfg_in.dim_enable        = csr_data[0];
            CSR_DIM_TIMEOUT: cfg_in.dim_timeout_ms    = csr_data[TIMEOUT_W-1:0];
            CSR_DIM_LEVEL:   cfg_in.dim_level_percent = csr_data[PCT_W-1:0];
            CSR_BRIGHT_MIN:  cfg_in.brightness_min    = csr_data[PCT_W-1:0];
            CSR_BRIGHT_MAX:  cfg_in.brightness_max    = csr_data[PCT_W-1:0];
            CSR_GRACE:       cfg_in.grace_ms          = csr_data[GRACE_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_enable        <= 1'b0;
         cfg_ff.dim_timeout_ms    <= RST_DIM_TIMEOUT;
         cfg_ff.dim_level_percent <= RST_DIM_LEVEL;
         cfg_ff.brightness_min    <= RST_BRIGHT_MIN;
         cfg_ff.brightness_max    <= RST_BRIGHT_MAX;
         cfg_ff.grace_ms          <= RST_GRACE;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

@@ rtl/core/bladc_core.sv @@
// ----------------------------------------------------------------------------
// bladc_core : event state and next-state logic
// Holds brightness, dim flag, duty and the two millisecond counters, and
// produces the result of one event combinationally from the held state.
// ----------------------------------------------------------------------------
module bladc_core
   import bladc_pkg::*;
#(
   parameter int unsigned DEFAULT_LEVEL = DEFAULT_LEVEL_DEF,
   parameter int unsigned DUTY_FULL     = DUTY_FULL_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   input  bladc_cfg_type             cfg,
   input  logic                      fire,
   input  logic [ACTION_W-1:0]       action,
   input  logic signed [DELTA_W-1:0] delta,
   output bladc_result_type          result
);

   localparam int unsigned LUT_DEPTH = 2 ** PCT_W;
   localparam int unsigned SUM_W     = PCT_W + 3;

   logic [DUTY_W-1:0] duty_lut [LUT_DEPTH];

   // percent to duty, clamped to 100 percent and to ten bits
   for (genvar p = 0; p < LUT_DEPTH; p++) begin : g_duty
      localparam int unsigned PCT = (p > PCT_LIMIT) ? PCT_LIMIT : p;
      localparam int unsigned RAW = (PCT * DUTY_FULL) / 100;
      assign duty_lut[p] = (RAW > DUTY_LIMIT) ? DUTY_W'(DUTY_LIMIT) : DUTY_W'(RAW);
   end

   logic [PCT_W-1:0]   level_ff, level_in;
   logic               dim_ff, dim_in;
   logic [DUTY_W-1:0]  duty_ff, duty_in;
   logic [COUNT_W-1:0] idle_ff, idle_in;
   logic [COUNT_W-1:0] wake_ff, wake_in;
   logic               woke_once_ff, woke_once_in;

   logic [COUNT_W-1:0] idle_inc, wake_inc;
   logic signed [SUM_W-1:0] sum, clamp_a, clamp_b, clamp_c, bmax, bmin;
   logic [PCT_W-1:0]   step_level;
   logic [PCT_W-1:0]   lut_pct;
   logic               woke;

   assign idle_inc = (idle_ff == '1) ? idle_ff : idle_ff + COUNT_W'(1);
   assign wake_inc = (wake_ff == '1) ? wake_ff : wake_ff + COUNT_W'(1);

   // step clamp: max first, then min, then the 0..100 range
   assign bmax    = signed'({3'b000, cfg.brightness_max});
   assign bmin    = signed'({3'b000, cfg.brightness_min});
   assign sum     = signed'({3'b000, level_ff}) + SUM_W'(delta);
   assign clamp_a = (sum > bmax) ? bmax : sum;
   assign clamp_b = (clamp_a < bmin) ? bmin : clamp_a;
   assign clamp_c = (clamp_b > SUM_W'(PCT_LIMIT)) ? SUM_W'(PCT_LIMIT) : clamp_b;
   assign step_level = (clamp_c < 0) ? '0 : clamp_c[PCT_W-1:0];

   always_comb begin
      lut_pct = level_ff;
      case (action)
         ACT_TICK: lut_pct = cfg.dim_level_percent;
         ACT_STEP: lut_pct = step_level;
         default:  lut_pct = level_ff;
      endcase
   end

   always_comb begin
      level_in     = level_ff;
      dim_in       = dim_ff;
      duty_in      = duty_ff;
      idle_in      = idle_ff;
      wake_in      = wake_ff;
      woke_once_in = woke_once_ff;
      woke         = 1'b0;
      case (action)
         ACT_TICK: begin
            idle_in = idle_inc;
            if (woke_once_ff) begin
               wake_in = wake_inc;
            end
            if (cfg.dim_enable && !dim_ff &&
                idle_inc >= COUNT_W'(cfg.dim_timeout_ms)) begin
               dim_in  = 1'b1;
               duty_in = duty_lut[lut_pct];
            end
         end
         ACT_ACTIVITY: begin
            idle_in = '0;
            if (dim_ff) begin
               woke         = 1'b1;
               dim_in       = 1'b0;
               wake_in      = '0;
               woke_once_in = 1'b1;
               duty_in      = duty_lut[lut_pct];
            end
         end
         ACT_STEP: begin
            level_in = step_level;
            duty_in  = duty_lut[lut_pct];
         end
         default: begin
            level_in = level_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff     <= PCT_W'(DEFAULT_LEVEL);
         dim_ff       <= 1'b0;
         duty_ff      <= '0;
         idle_ff      <= '0;
         wake_ff      <= '0;
         woke_once_ff <= 1'b0;
      end else if (fire) begin
         level_ff     <= level_in;
         dim_ff       <= dim_in;
         duty_ff      <= duty_in;
         idle_ff      <= idle_in;
         wake_ff      <= wake_in;
         woke_once_ff <= woke_once_in;
      end
   end

   assign result.duty       = duty_in;
   assign result.is_dimmed  = dim_in;
   assign result.woke_up    = woke;
   assign result.in_grace   = woke_once_in && (wake_in < COUNT_W'(cfg.grace_ms));
   assign result.brightness = level_in;

endmodule

@@ rtl/core/backlight_auto_dim_controller.sv @@
// ----------------------------------------------------------------------------
// backlight_auto_dim_controller : inactivity auto-dim for a display backlight
// Event-driven controller that tracks brightness, dims after idle time and
// reports the PWM duty with dimmed, wake and grace status for every event.
// ----------------------------------------------------------------------------
// Each event (tick, activity or brightness step) yields exactly one result.
// An item is captured in the input register, evaluated combinationally
// against the controller state and lands in the result register, from which
// it shows on the rsp_ port; one item is taken every cycle while the result
// side keeps up. The state update loop (brightness, dim flag, idle and
// since-wake counters) sets that throughput. Stall on the result side backs
// up through the input register. Settings must be written through the csr_
// port only while no event is in flight; the block does not enforce this.
// There is no read-back.
// ----------------------------------------------------------------------------
module backlight_auto_dim_controller
   import bladc_pkg::*;
#(
   parameter int unsigned DEFAULT_LEVEL = DEFAULT_LEVEL_DEF,
   parameter int unsigned DUTY_FULL     = DUTY_FULL_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // event input
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [ACTION_W-1:0]       req_action,
   input  logic signed [DELTA_W-1:0] req_brightness_delta,
   // result output
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [DUTY_W-1:0]         rsp_duty,
   output logic                      rsp_is_dimmed,
   output logic                      rsp_woke_up,
   output logic                      rsp_in_grace,
   output logic [PCT_W-1:0]          rsp_brightness,
   // configuration writes
   input  logic                      csr_write_enable,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [CSR_DAT_W-1:0]      csr_data
);

   bladc_cfg_type    cfg;
   bladc_result_type result;
   bladc_result_type rsp_ff;

   logic                      in_valid_ff;
   logic [ACTION_W-1:0]       in_action_ff;
   logic signed [DELTA_W-1:0] in_delta_ff;
   logic                      rsp_valid_ff;

   logic out_open;   // result register can take a new item this cycle
   logic fire;       // input register item is evaluated and moves on
   logic req_take;

   assign out_open  = !rsp_valid_ff || !rsp_stall;
   assign fire      = in_valid_ff && out_open;
   assign req_stall = in_valid_ff && !out_open;
   assign req_take  = req_valid && !req_stall;

   bladc_csr u_csr (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .cfg              (cfg)
   );

   bladc_core #(
      .DEFAULT_LEVEL (DEFAULT_LEVEL),
      .DUTY_FULL     (DUTY_FULL)
   ) u_core (
      .clock  (clock),
      .reset  (reset),
      .cfg    (cfg),
      .fire   (fire),
      .action (in_action_ff),
      .delta  (in_delta_ff),
      .result (result)
   );

   // input register: refill whenever the held item moves on or it is empty
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (!req_stall) begin
         in_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_action_ff <= req_action;
         in_delta_ff  <= req_brightness_delta;
      end
   end

   // result register: hold while the consumer stalls
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_open) begin
         rsp_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_duty       = rsp_ff.duty;
   assign rsp_is_dimmed  = rsp_ff.is_dimmed;
   assign rsp_woke_up    = rsp_ff.woke_up;
   assign rsp_in_grace   = rsp_ff.in_grace;
   assign rsp_brightness = rsp_ff.brightness;

endmodule

@@ bench/tb.sv @@
// ----------------------------------------------------------------------------
// tb : testbench for the backlight auto-dim controller
// Sends tick, activity, brightness-step and unused-code items with random
// gaps and result-side stalls. Every result is predicted from a private copy
// of the controller state and settings, then compared field by field.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import bladc_pkg::*;

   // action 3 has no name in the package; the block must leave state alone
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   localparam int unsigned DEFAULT_LEVEL  = 80;
   localparam int unsigned DUTY_FULL      = 1023;
   localparam int          WATCHDOG_LIMIT = 2000;
   // extra margin after the last predicted result has come back
   localparam int          DRAIN_CYCLES   = 4;
   localparam int          PHASES         = 8;
   localparam int          PHASE_ITEMS    = 250;

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [ACTION_W-1:0]       req_action;
   logic signed [DELTA_W-1:0] req_brightness_delta;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [DUTY_W-1:0]         rsp_duty;
   logic                      rsp_is_dimmed;
   logic                      rsp_woke_up;
   logic                      rsp_in_grace;
   logic [PCT_W-1:0]          rsp_brightness;
   logic                      csr_write_enable;
   logic [CSR_IDX_W-1:0]      csr_index;
   logic [CSR_DAT_W-1:0]      csr_data;

   backlight_auto_dim_controller #(
      .DEFAULT_LEVEL (DEFAULT_LEVEL),
      .DUTY_FULL     (DUTY_FULL)
   ) dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_action           (req_action),
      .req_brightness_delta (req_brightness_delta),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_duty             (rsp_duty),
      .rsp_is_dimmed        (rsp_is_dimmed),
      .rsp_woke_up          (rsp_woke_up),
      .rsp_in_grace         (rsp_in_grace),
      .rsp_brightness       (rsp_brightness),
      .csr_write_enable     (csr_write_enable),
      .csr_index            (csr_index),
      .csr_data             (csr_data)
   );

   // Private copy of the controller: settings plus the six state registers.
   bladc_cfg_type      settings;
   logic [PCT_W-1:0]   user_level;
   logic               dimmed;
   logic [DUTY_W-1:0]  driven_duty;
   logic [COUNT_W-1:0] idle_count;
   logic [COUNT_W-1:0] since_wake;
   logic               has_woken;

   bladc_result_type   pending_status[$];
   int                 mismatches;
   int                 quiet_cycles;
   // high during the long stretch where neither side idles
   bit                 idle_free;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Scale a percentage to PWM duty; clip the percentage to 100 and the
   // duty to ten bits.
   function automatic logic [DUTY_W-1:0] duty_of_percent(input int unsigned pct);
      int unsigned d;
      if (pct > PCT_LIMIT) pct = PCT_LIMIT;
      d = pct * DUTY_FULL / PCT_LIMIT;
      if (d > DUTY_LIMIT) d = DUTY_LIMIT;
      return d[DUTY_W-1:0];
   endfunction

   // Advance the private controller by one item and return the status it
   // reports.
   function automatic bladc_result_type advance_backlight(
      input logic [ACTION_W-1:0]       action,
      input logic signed [DELTA_W-1:0] delta
   );
      bladc_result_type status;
      logic             woke;
      int               level;
      woke = 1'b0;
      case (action)
         ACT_TICK: begin
            // both counters saturate instead of wrapping
            if (idle_count != '1) idle_count = idle_count + 1;
            if (has_woken && since_wake != '1) since_wake = since_wake + 1;
            if (settings.dim_enable && !dimmed && idle_count >= settings.dim_timeout_ms) begin
               dimmed      = 1'b1;
               driven_duty = duty_of_percent(32'(settings.dim_level_percent));
            end
         end
         ACT_ACTIVITY: begin
            // activity while awake clears only the idle time
            idle_count = '0;
            if (dimmed) begin
               woke        = 1'b1;
               dimmed      = 1'b0;
               since_wake  = '0;
               has_woken   = 1'b1;
               driven_duty = duty_of_percent(32'(user_level));
            end
         end
         ACT_STEP: begin
            // lower to max first, then raise to min, so min wins when crossed
            level = int'(user_level) + int'(delta);
            if (level > int'(settings.brightness_max)) level = int'(settings.brightness_max);
            if (level < int'(settings.brightness_min)) level = int'(settings.brightness_min);
            if (level > int'(PCT_LIMIT)) level = int'(PCT_LIMIT);
            if (level < 0) level = 0;
            user_level = level[PCT_W-1:0];
            // duty follows the new level even while dimmed; the dimmed flag holds
            driven_duty = duty_of_percent(32'(user_level));
         end
         default: ;
      endcase
      status.duty       = driven_duty;
      status.is_dimmed  = dimmed;
      status.woke_up    = woke;
      status.in_grace   = has_woken && (since_wake < settings.grace_ms);
      status.brightness = user_level;
      return status;
   endfunction

   function automatic bladc_cfg_type settings_of(
      input bit          enable,
      input int unsigned timeout,
      input int unsigned dim_level,
      input int unsigned level_min,
      input int unsigned level_max,
      input int unsigned grace
   );
      bladc_cfg_type c;
      c.dim_enable        = enable;
      c.dim_timeout_ms    = timeout[TIMEOUT_W-1:0];
      c.dim_level_percent = dim_level[PCT_W-1:0];
      c.brightness_min    = level_min[PCT_W-1:0];
      c.brightness_max    = level_max[PCT_W-1:0];
      c.grace_ms          = grace[GRACE_W-1:0];
      return c;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      mismatches++;
   endtask

   task automatic check_field(input string name, input logic [31:0] got,
                              input logic [31:0] want);
      if (got !== want)
         report_mismatch($sformatf("%s got %0d expected %0d", name, got, want));
   endtask

   // Predict at input acceptance and compare at result acceptance in one
   // process, so a same-edge push and pop always happen in that order.
   always @(posedge clock) begin : track_results
      bladc_result_type want;
      if (!reset) begin
         if (req_valid && !req_stall)
            pending_status.push_back(advance_backlight(req_action, req_brightness_delta));
         if (rsp_valid && !rsp_stall) begin
            if (pending_status.size() == 0) begin
               report_mismatch($sformatf("unexpected result, duty %0d", rsp_duty));
            end else begin
               want = pending_status.pop_front();
               check_field("duty", 32'(rsp_duty), 32'(want.duty));
               check_field("is_dimmed", 32'(rsp_is_dimmed), 32'(want.is_dimmed));
               check_field("woke_up", 32'(rsp_woke_up), 32'(want.woke_up));
               check_field("in_grace", 32'(rsp_in_grace), 32'(want.in_grace));
               check_field("brightness", 32'(rsp_brightness), 32'(want.brightness));
            end
         end
      end
   end

   // Stall the result side with a probability of about 22 percent, except in
   // the idle-free stretch.
   always @(negedge clock) begin
      rsp_stall <= !reset && !idle_free && ($urandom_range(0, 99) < 22);
   end

   // Abort when nothing moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // Send one item: maybe idle first, then hold it until taken.
   task automatic send_event(input logic [ACTION_W-1:0] action, input int delta);
      int gap;
      if (!idle_free && $urandom_range(0, 99) < 22) begin
         gap = $urandom_range(1, 3);
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid            <= 1'b1;
      req_action           <= action;
      req_brightness_delta <= delta[DELTA_W-1:0];
      do @(posedge clock); while (req_stall);
   endtask

   // Drop valid and wait until every predicted result has come back.
   task automatic wait_drained();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_status.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index,
                                 input logic [CSR_DAT_W-1:0] data);
      @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= data;
   endtask

   // Write all six registers while the block is idle, then track them.
   task automatic apply_settings(input bladc_cfg_type c);
      wait_drained();
      write_register(CSR_DIM_ENABLE, CSR_DAT_W'(c.dim_enable));
      write_register(CSR_DIM_TIMEOUT, CSR_DAT_W'(c.dim_timeout_ms));
      write_register(CSR_DIM_LEVEL, CSR_DAT_W'(c.dim_level_percent));
      write_register(CSR_BRIGHT_MIN, CSR_DAT_W'(c.brightness_min));
      write_register(CSR_BRIGHT_MAX, CSR_DAT_W'(c.brightness_max));
      write_register(CSR_GRACE, CSR_DAT_W'(c.grace_ms));
      @(negedge clock);
      csr_write_enable <= 1'b0;
      settings = c;
   endtask

   // Reset settings, dimming off: duty reads 0 until an item drives one.
   task automatic test_power_on_status();
      send_event(ACT_TICK, -100);
      send_event(ACT_UNUSED, 100);
      send_event(ACT_ACTIVITY, 0);
      send_event(ACT_STEP, 0);
   endtask

   // Brightness steps against the bounds, including crossed bounds and a
   // minimum above 100.
   task automatic test_brightness_limits();
      apply_settings(settings_of(1'b0, 30000, 10, 0, 100, 500));
      send_event(ACT_STEP, 100);
      send_event(ACT_STEP, 1);
      send_event(ACT_STEP, -100);
      send_event(ACT_STEP, -1);
      send_event(ACT_STEP, 37);
      apply_settings(settings_of(1'b0, 30000, 10, 60, 40, 500));
      send_event(ACT_STEP, -100);
      apply_settings(settings_of(1'b0, 30000, 10, 120, 127, 500));
      send_event(ACT_STEP, 100);
      apply_settings(settings_of(1'b0, 30000, 10, 0, 0, 500));
      send_event(ACT_STEP, 100);
   endtask

   // Zero timeout, dim level above 100, step while dimmed, wake, grace
   // expiry and activity while awake.
   task automatic test_dim_and_wake();
      apply_settings(settings_of(1'b1, 0, 127, 5, 100, 2));
      send_event(ACT_TICK, 0);
      send_event(ACT_STEP, 50);
      send_event(ACT_ACTIVITY, 0);
      send_event(ACT_ACTIVITY, 0);
      send_event(ACT_TICK, 0);
      send_event(ACT_TICK, 0);
      send_event(ACT_ACTIVITY, 0);
      apply_settings(settings_of(1'b1, 3, 0, 5, 100, 0));
      send_event(ACT_TICK, 0);
      send_event(ACT_TICK, 0);
      send_event(ACT_TICK, 0);
      send_event(ACT_ACTIVITY, 0);
   endtask

   // Random traffic over several settings; short timeouts in most phases keep
   // the dim and wake paths busy.
   task automatic test_random_traffic();
      bladc_cfg_type c;
      int            pick;
      int unsigned   level_min;
      int unsigned   level_max;
      for (int phase = 0; phase < PHASES; phase++) begin
         level_min = $urandom_range(0, 60);
         level_max = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 100)
                                                 : $urandom_range(level_min, 100);
         case (phase)
            0:       c = settings_of(1'b1, 86400000, 100, 0, 100, 65535);
            1:       c = settings_of(1'b1, 1, 0, 100, 100, 0);
            default: c = settings_of($urandom_range(0, 9) != 0, $urandom_range(0, 15),
                                     $urandom_range(0, 127), level_min, level_max,
                                     $urandom_range(0, 40));
         endcase
         apply_settings(c);
         idle_free = (phase == 2);
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            pick = $urandom_range(0, 99);
            if (pick < 60)      send_event(ACT_TICK, $urandom_range(0, 200) - 100);
            else if (pick < 71) send_event(ACT_ACTIVITY, $urandom_range(0, 200) - 100);
            else if (pick < 94) send_event(ACT_STEP, $urandom_range(0, 200) - 100);
            else                send_event(ACT_UNUSED, $urandom_range(0, 200) - 100);
         end
         idle_free = 1'b0;
      end
   endtask

   initial begin
      // drive every input from time zero while reset is held
      reset                = 1'b1;
      req_valid            = 1'b0;
      req_action           = ACT_TICK;
      req_brightness_delta = '0;
      rsp_stall            = 1'b0;
      csr_write_enable     = 1'b0;
      csr_index            = CSR_DIM_ENABLE;
      csr_data             = '0;
      mismatches           = 0;
      quiet_cycles         = 0;
      idle_free            = 1'b0;
      settings             = settings_of(1'b0, 32'(RST_DIM_TIMEOUT), 32'(RST_DIM_LEVEL),
                                         32'(RST_BRIGHT_MIN), 32'(RST_BRIGHT_MAX),
                                         32'(RST_GRACE));
      user_level           = PCT_W'(DEFAULT_LEVEL);
      dimmed               = 1'b0;
      driven_duty          = '0;
      idle_count           = '0;
      since_wake           = '0;
      has_woken            = 1'b0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_power_on_status();
      test_brightness_limits();
      test_dim_and_wake();
      test_random_traffic();

      wait_drained();
      if (mismatches == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ backlight_auto_dim_controller.f @@
rtl/core/bladc_pkg.sv
rtl/core/bladc_csr.sv
rtl/core/bladc_core.sv
rtl/core/backlight_auto_dim_controller.sv
bench/tb.sv
